@@ design/pdc_pkg.sv @@
// Shared types, codes and arithmetic helpers of the Porter-Duff pixel compositor.
package pdc_pkg;

   localparam int PDC_LANES  = 4;
   localparam int ALPHA_LANE = 3;

   // Composition mode codes.
   localparam logic [3:0] MODE_CLEAR    = 4'd0;
   localparam logic [3:0] MODE_SRC      = 4'd1;
   localparam logic [3:0] MODE_DST      = 4'd2;
   localparam logic [3:0] MODE_SRC_OVER = 4'd3;
   localparam logic [3:0] MODE_DST_OVER = 4'd4;
   localparam logic [3:0] MODE_SRC_IN   = 4'd5;
   localparam logic [3:0] MODE_DST_IN   = 4'd6;
   localparam logic [3:0] MODE_SRC_OUT  = 4'd7;
   localparam logic [3:0] MODE_DST_OUT  = 4'd8;
   localparam logic [3:0] MODE_SRC_ATOP = 4'd9;
   localparam logic [3:0] MODE_DST_ATOP = 4'd10;
   localparam logic [3:0] MODE_XOR      = 4'd11;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_MODE   = 1'd0;
   localparam logic [0:0] REG_OPAQUE = 1'd1;

   // How the second blend layer and the final selection treat a beat.
   localparam logic [1:0] KIND_MIX    = 2'd0;
   localparam logic [1:0] KIND_OVER   = 2'd1;
   localparam logic [1:0] KIND_OPAQUE = 2'd2;
   localparam logic [1:0] KIND_PASS   = 2'd3;

   localparam logic [7:0] FULL_ALPHA = 8'hff;

   // One lane computes sat8(addend + div255(a * fa + b * fb)).
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] fa;
      logic [7:0] b;
      logic [7:0] fb;
      logic [7:0] addend;
   } pdc_lane_op_type;

   typedef pdc_lane_op_type [PDC_LANES-1:0] pdc_px_op_type;

   // Sideband that travels alongside a beat through the blend layers.
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] tpix;
      logic [7:0]  cov;
      logic [1:0]  kind;
   } pdc_side_type;

   // Rounding division by 255 in the shift form.
   function automatic logic [9:0] div255(input logic [16:0] x);
      logic [17:0] s;
      s = {1'b0, x} + {9'd0, x[16:8]} + 18'd128;
      return s[17:8];
   endfunction

   function automatic logic [7:0] sat8(input logic [10:0] v);
      return (v > 11'd255) ? 8'hff : v[7:0];
   endfunction

endpackage

@@ design/pdc_blend_layer.sv @@
// Two-stage blend layer: four lane multiply-adds, then division by 255, addend and saturation.
module pdc_blend_layer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pdc_pkg::pdc_px_op_type in_ops,
   input  pdc_pkg::pdc_side_type  in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [31:0]            out_pix,
   output pdc_pkg::pdc_side_type  out_side
);

   logic                  prod_valid_ff;
   logic [16:0]           prod_ff [pdc_pkg::PDC_LANES];
   logic [16:0]           prod_in [pdc_pkg::PDC_LANES];
   logic [7:0]            addend_ff [pdc_pkg::PDC_LANES];
   pdc_pkg::pdc_side_type prod_side_ff;

   logic                  pix_valid_ff;
   logic [31:0]           pix_ff;
   logic [31:0]           pix_in;
   pdc_pkg::pdc_side_type pix_side_ff;

   logic                  prod_ready;
   logic                  pix_ready;

   assign pix_ready  = !pix_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || pix_ready;
   assign in_ready   = prod_ready;

   always_comb begin
      logic [15:0] p1;
      logic [15:0] p2;
      for (int k = 0; k < pdc_pkg::PDC_LANES; k++) begin
         p1 = 16'(in_ops[k].a) * 16'(in_ops[k].fa);
         p2 = 16'(in_ops[k].b) * 16'(in_ops[k].fb);
         prod_in[k] = {1'b0, p1} + {1'b0, p2};
      end
   end

   always_comb begin
      for (int k = 0; k < pdc_pkg::PDC_LANES; k++) begin
         pix_in[8*k +: 8] = pdc_pkg::sat8({1'b0, pdc_pkg::div255(prod_ff[k])} +
                                          {3'd0, addend_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (pix_ready) begin
            pix_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         for (int k = 0; k < pdc_pkg::PDC_LANES; k++) begin
            prod_ff[k]   <= prod_in[k];
            addend_ff[k] <= in_ops[k].addend;
         end
         prod_side_ff <= in_side;
      end
      if (pix_ready && prod_valid_ff) begin
         pix_ff      <= pix_in;
         pix_side_ff <= prod_side_ff;
      end
   end

   assign out_valid = pix_valid_ff;
   assign out_pix   = pix_ff;
   assign out_side  = pix_side_ff;

endmodule

@@ design/porter_duff_pixel_compositor_unit.sv @@
// Top level of the Porter-Duff pixel compositor for premultiplied ARGB32 pixels.
//
// Each beat on the req_ channel carries a destination pixel, a source pixel and an
// 8-bit coverage; each beat on the rsp_ channel carries the composited pixel, one
// result per request, in order. Both channels use a valid/ready handshake.
// The csr_ port writes the composition mode (index 0) and the opaque-target flag
// (index 1); the user writes it only with no beat in flight, unenforced by the block.
// A beat passes an input register, two blend layers of two stages each (multiply,
// then division by 255 with saturation) and an output register. The first layer
// forms the mode's result or the coverage-scaled source; the second layer forms the
// source-over blend or the coverage mix with the old destination.
// One beat is accepted every cycle while the receiver does not stall; the rate is set
// by the single 8x8 multiplier pair per lane in each layer.
// When the receiver stalls, each stage holds its beat and empty stages further up
// still fill, so up to six beats are held before req_ready falls.
// Reset empties every stage and sets the mode to source-over with opaque-target off.
module porter_duff_pixel_compositor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_dest_pixel,
   input  logic [31:0] req_src_pixel,
   input  logic [7:0]  req_coverage,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_pixel,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   // Configuration registers.
   logic [3:0] mode_ff;
   logic       opaque_ff;

   // Input register stage.
   logic        s0_valid_ff;
   logic [31:0] s0_dest_ff;
   logic [31:0] s0_src_ff;
   logic [7:0]  s0_cov_ff;
   logic [3:0]  s0_mode_ff;
   logic [1:0]  s0_kind_ff;
   logic [1:0]  s0_kind_in;
   logic        s0_ready;

   // Blend layer connections.
   pdc_pkg::pdc_px_op_type l1_ops;
   pdc_pkg::pdc_side_type  l1_in_side;
   logic                   l1_in_ready;
   logic                   l1_out_valid;
   logic [31:0]            l1_pix;
   pdc_pkg::pdc_side_type  l1_side;

   pdc_pkg::pdc_px_op_type l2_ops;
   pdc_pkg::pdc_side_type  l2_in_side;
   logic                   l2_in_ready;
   logic                   l2_out_valid;
   logic                   l2_out_ready;
   logic [31:0]            l2_pix;
   pdc_pkg::pdc_side_type  l2_side;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_pix_ff;
   logic [31:0] final_pix;

   // Count of beats held anywhere in the block.
   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;

   logic req_take;
   logic rsp_take;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign s0_ready  = !s0_valid_ff || l1_in_ready;
   assign req_ready = s0_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pdc_pkg::MODE_SRC_OVER;
         opaque_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pdc_pkg::REG_MODE:   mode_ff   <= csr_wdata;
            pdc_pkg::REG_OPAQUE: opaque_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The opaque-target flag overrides the mode; unused mode codes pass the destination.
   always_comb begin
      if (opaque_ff) begin
         s0_kind_in = pdc_pkg::KIND_OPAQUE;
      end else if (mode_ff == pdc_pkg::MODE_SRC_OVER) begin
         s0_kind_in = pdc_pkg::KIND_OVER;
      end else if (mode_ff > pdc_pkg::MODE_XOR) begin
         s0_kind_in = pdc_pkg::KIND_PASS;
      end else begin
         s0_kind_in = pdc_pkg::KIND_MIX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_dest_ff <= req_dest_pixel;
         s0_src_ff  <= req_src_pixel;
         s0_cov_ff  <= req_coverage;
         s0_mode_ff <= mode_ff;
         s0_kind_ff <= s0_kind_in;
      end
   end

   // First layer operands: the mode's own result, or the source scaled by coverage.
   always_comb begin
      logic [7:0] sa;
      logic [7:0] da;
      logic [7:0] sk;
      logic [7:0] dk;
      sa = s0_src_ff[31:24];
      da = s0_dest_ff[31:24];
      l1_ops = '0;
      for (int k = 0; k < pdc_pkg::PDC_LANES; k++) begin
         sk = s0_src_ff[8*k +: 8];
         dk = s0_dest_ff[8*k +: 8];
         if (s0_kind_ff == pdc_pkg::KIND_OVER || s0_kind_ff == pdc_pkg::KIND_OPAQUE) begin
            l1_ops[k].a  = sk;
            l1_ops[k].fa = s0_cov_ff;
         end else begin
            unique case (s0_mode_ff)
               pdc_pkg::MODE_CLEAR: ;
               pdc_pkg::MODE_SRC: begin
                  l1_ops[k].addend = sk;
               end
               pdc_pkg::MODE_DST_OVER: begin
                  l1_ops[k].a      = sk;
                  l1_ops[k].fa     = ~da;
                  l1_ops[k].addend = dk;
               end
               pdc_pkg::MODE_SRC_IN: begin
                  l1_ops[k].a  = sk;
                  l1_ops[k].fa = da;
               end
               pdc_pkg::MODE_DST_IN: begin
                  l1_ops[k].a  = dk;
                  l1_ops[k].fa = sa;
               end
               pdc_pkg::MODE_SRC_OUT: begin
                  l1_ops[k].a  = sk;
                  l1_ops[k].fa = ~da;
               end
               pdc_pkg::MODE_DST_OUT: begin
                  l1_ops[k].a  = dk;
                  l1_ops[k].fa = ~sa;
               end
               pdc_pkg::MODE_SRC_ATOP: begin
                  if (k == pdc_pkg::ALPHA_LANE) begin
                     l1_ops[k].addend = da;
                  end else begin
                     l1_ops[k].a  = sk;
                     l1_ops[k].fa = da;
                     l1_ops[k].b  = dk;
                     l1_ops[k].fb = ~sa;
                  end
               end
               pdc_pkg::MODE_DST_ATOP: begin
                  if (k == pdc_pkg::ALPHA_LANE) begin
                     l1_ops[k].addend = sa;
                  end else begin
                     l1_ops[k].a  = dk;
                     l1_ops[k].fa = sa;
                     l1_ops[k].b  = sk;
                     l1_ops[k].fb = ~da;
                  end
               end
               pdc_pkg::MODE_XOR: begin
                  l1_ops[k].a  = sk;
                  l1_ops[k].fa = ~da;
                  l1_ops[k].b  = dk;
                  l1_ops[k].fb = ~sa;
               end
               default: begin
                  // Destination mode and the unused codes both give the destination.
                  l1_ops[k].addend = dk;
               end
            endcase
         end
      end
   end

   always_comb begin
      l1_in_side      = '0;
      l1_in_side.dest = s0_dest_ff;
      l1_in_side.cov  = s0_cov_ff;
      l1_in_side.kind = s0_kind_ff;
   end

   pdc_blend_layer u_layer1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (l1_in_ready),
      .in_ops    (l1_ops),
      .in_side   (l1_in_side),
      .out_valid (l1_out_valid),
      .out_ready (l2_in_ready),
      .out_pix   (l1_pix),
      .out_side  (l1_side)
   );

   // Second layer operands: source-over of the scaled source, or the coverage mix.
   always_comb begin
      logic [7:0] ma;
      logic [7:0] dk;
      ma     = l1_pix[31:24];
      l2_ops = '0;
      for (int k = 0; k < pdc_pkg::PDC_LANES; k++) begin
         dk = l1_side.dest[8*k +: 8];
         case (l1_side.kind)
            pdc_pkg::KIND_OVER, pdc_pkg::KIND_OPAQUE: begin
               l2_ops[k].b      = dk;
               l2_ops[k].fb     = ~ma;
               l2_ops[k].addend = l1_pix[8*k +: 8];
            end
            pdc_pkg::KIND_MIX: begin
               l2_ops[k].a  = l1_pix[8*k +: 8];
               l2_ops[k].fa = l1_side.cov;
               l2_ops[k].b  = dk;
               l2_ops[k].fb = ~l1_side.cov;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      l2_in_side      = l1_side;
      l2_in_side.tpix = l1_pix;
   end

   pdc_blend_layer u_layer2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_out_valid),
      .in_ready  (l2_in_ready),
      .in_ops    (l2_ops),
      .in_side   (l2_in_side),
      .out_valid (l2_out_valid),
      .out_ready (l2_out_ready),
      .out_pix   (l2_pix),
      .out_side  (l2_side)
   );

   // Final choice between the blended pixel and the short cuts of each kind.
   always_comb begin
      logic [7:0] ta;
      ta = l2_side.tpix[31:24];
      case (l2_side.kind)
         pdc_pkg::KIND_OVER: begin
            if (ta == 8'd0) begin
               final_pix = l2_side.dest;
            end else if (ta == pdc_pkg::FULL_ALPHA) begin
               final_pix = l2_side.tpix;
            end else begin
               final_pix = l2_pix;
            end
         end
         pdc_pkg::KIND_OPAQUE: begin
            if (ta == pdc_pkg::FULL_ALPHA) begin
               final_pix = l2_side.tpix;
            end else begin
               final_pix = {pdc_pkg::FULL_ALPHA, l2_pix[23:0]};
            end
         end
         pdc_pkg::KIND_MIX: begin
            if (l2_side.cov == pdc_pkg::FULL_ALPHA) begin
               final_pix = l2_side.tpix;
            end else begin
               final_pix = l2_pix;
            end
         end
         default: begin
            final_pix = l2_side.tpix;
         end
      endcase
   end

   assign l2_out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (l2_out_ready) begin
         rsp_valid_ff <= l2_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (l2_out_ready && l2_out_valid) begin
         rsp_pix_ff <= final_pix;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pix_ff;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (!req_take && rsp_take) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 3'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // The block holds at most one beat per stage.
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd6)
      else $error("more beats in flight than the pipeline has stages");

   // With nothing in flight, neither end register may claim a beat.
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 3'd0) |-> (!rsp_valid_ff && !s0_valid_ff))
      else $error("stage valid set while no beat is in flight");

   // A beat handed from the second layer shows up at the output next cycle.
   a_layer_to_output: assert property (@(posedge clock) disable iff (reset)
      (l2_out_valid && l2_out_ready) |=> rsp_valid_ff)
      else $error("beat from the second blend layer was lost");

   // An opaque target always receives a fully opaque pixel.
   a_opaque_alpha: assert property (@(posedge clock) disable iff (reset)
      (l2_out_valid && (l2_side.kind == pdc_pkg::KIND_OPAQUE))
         |-> (final_pix[31:24] == pdc_pkg::FULL_ALPHA))
      else $error("opaque target result without full alpha");

endmodule
